### rtl/core/bffa_pkg.sv
// Shared types and constants of the bitmap first-fit allocator.
// Used by the interfaces, the scan unit, the register block and the top level.
`default_nettype none
package bffa_pkg;

	localparam int WORD_W  = 32;
	localparam int OFF_W   = 5;
	localparam int CNT_W   = 11;
	localparam int IDX_W   = 10;
	localparam int WPTR_W  = 6;
	localparam int STAT_W  = 2;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [STAT_W-1:0] STAT_OK           = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_FREE      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE        = 2'd2;
	localparam logic [STAT_W-1:0] STAT_ALREADY_FREE = 2'd3;

	localparam logic REG_ENTRY_COUNT = 1'b0;
	localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = 11'd1024;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [CNT_W-1:0]  base;
		logic [CNT_W-1:0]  lo;
		logic [CNT_W-1:0]  hi;
	} scan_req_t;

	typedef struct packed {
		logic             found;
		logic [CNT_W-1:0] index;
	} scan_rsp_t;

endpackage
`default_nettype wire

### rtl/core/bffa_if.sv
// Request and response channel interfaces of the allocator.
// Depends on bffa_pkg for the field widths.
`default_nettype none
interface bffa_req_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [bffa_pkg::IDX_W-1:0]  entry_index;

	modport source(output valid, mode, entry_index, input ready);
	modport sink(input valid, mode, entry_index, output ready);
endinterface

interface bffa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bffa_pkg::STAT_W-1:0] status;
	logic [bffa_pkg::IDX_W-1:0]  granted_index;
	logic [bffa_pkg::CNT_W-1:0]  free_count;
	logic [bffa_pkg::CNT_W-1:0]  first_free_hint;

	modport source(output valid, status, granted_index, free_count, first_free_hint,
		input ready);
	modport sink(input valid, status, granted_index, free_count, first_free_hint,
		output ready);
endinterface
`default_nettype wire

### rtl/core/bffa_map_ram.sv
// Word-wide used-map memory with one write port and one registered read port.
// Depends on bffa_pkg for the word width; the top level sizes it from the pool size.
`default_nettype none
module bffa_map_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [AW-1:0]                 wr_addr,
	input  wire logic [bffa_pkg::WORD_W-1:0]   wr_data,
	input  wire logic                          re,
	input  wire logic [AW-1:0]                 rd_addr,
	output      logic [bffa_pkg::WORD_W-1:0]   rd_data
);

	logic [bffa_pkg::WORD_W-1:0] mem [DEPTH];
	logic [bffa_pkg::WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

### rtl/core/bffa_scan.sv
// Shared find-first-free unit: lowest clear bit of one map word within a window.
// Depends on bffa_pkg for the request and result structs.
`default_nettype none
module bffa_scan (
	input  wire bffa_pkg::scan_req_t req,
	output      bffa_pkg::scan_rsp_t rsp
);

	logic [bffa_pkg::CNT_W:0]      base_x;
	logic [bffa_pkg::CNT_W:0]      lo_d;
	logic [bffa_pkg::CNT_W:0]      hi_d;
	logic [bffa_pkg::WORD_W-1:0]   lo_mask;
	logic [bffa_pkg::WORD_W-1:0]   hi_mask;
	logic [bffa_pkg::WORD_W-1:0]   cand;
	logic [bffa_pkg::OFF_W-1:0]    off;
	logic                          found;

	always_comb begin
		base_x = {1'b0, req.base};
		lo_d = {1'b0, req.lo} - base_x;
		hi_d = {1'b0, req.hi} - base_x;

		if (req.lo <= req.base) begin
			lo_mask = '1;
		end else if (lo_d >= 12'(bffa_pkg::WORD_W)) begin
			lo_mask = '0;
		end else begin
			lo_mask = ~((32'd1 << lo_d[bffa_pkg::OFF_W-1:0]) - 32'd1);
		end

		if (req.hi <= req.base) begin
			hi_mask = '0;
		end else if (hi_d >= 12'(bffa_pkg::WORD_W)) begin
			hi_mask = '1;
		end else begin
			hi_mask = (32'd1 << hi_d[bffa_pkg::OFF_W-1:0]) - 32'd1;
		end

		cand = ~req.word & lo_mask & hi_mask;
		found = 1'b0;
		off = '0;
		for (int b = bffa_pkg::WORD_W - 1; b >= 0; b--) begin
			if (cand[b]) begin
				found = 1'b1;
				off = 5'(b);
			end
		end
	end

	assign rsp.found = found;
	assign rsp.index = {req.base[bffa_pkg::CNT_W-1:bffa_pkg::OFF_W], off};

endmodule
`default_nettype wire

### rtl/core/bffa_cfg.sv
// APB register block holding the entry_count register.
// Depends on bffa_pkg for the address map and reset value.
`default_nettype none
module bffa_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bffa_pkg::APB_AW-1:0]   paddr,
	input  wire logic [bffa_pkg::APB_DW-1:0]   pwdata,
	output      logic [bffa_pkg::APB_DW-1:0]   prdata,
	output      logic                          pready,
	output      logic [bffa_pkg::CNT_W-1:0]    entry_count
);

	logic [bffa_pkg::CNT_W-1:0] entry_count_q;
	logic                       sel_count;

	assign sel_count = (paddr[2] == bffa_pkg::REG_ENTRY_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= bffa_pkg::ENTRY_COUNT_RST;
		end else if (psel && penable && pwrite && sel_count) begin
			entry_count_q <= pwdata[bffa_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_count) begin
			prdata = {{(bffa_pkg::APB_DW - bffa_pkg::CNT_W){1'b0}}, entry_count_q};
		end
	end

	assign pready = 1'b1;
	assign entry_count = entry_count_q;

endmodule
`default_nettype wire

### rtl/core/bitmap_first_fit_allocator.sv
// Bitmap first-fit allocator: the used-map is held as 32-bit words in a RAM and walked one
// word at a time by a single find-first-free unit, each word visited in a read state and
// then a scan state. A free reads the word of its index, checks and clears the bit, then
// loads its result register; an index out of range goes straight to the result. An
// allocation reads and scans words until it finds and marks the first free entry, then
// scans the rest of that word and further words for the next free entry as the hint. An
// allocation that finds nothing free ends after the last word, one with a count of zero at
// once. A result is loaded only once the previous one has been taken. The block takes one
// item at a time and is ready again in the cycle after its result has been loaded. After
// reset the map is cleared one word per cycle, all ceil(MAX_ENTRIES/32) words (32 at the
// default), and no item is accepted meanwhile.
`default_nettype none
module bitmap_first_fit_allocator #(
	parameter int MAX_ENTRIES = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	bffa_req_if.sink                           req,
	bffa_rsp_if.source                         rsp,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bffa_pkg::APB_AW-1:0]   paddr,
	input  wire logic [bffa_pkg::APB_DW-1:0]   pwdata,
	output      logic [bffa_pkg::APB_DW-1:0]   prdata,
	output      logic                          pready
);

	localparam int CW        = bffa_pkg::CNT_W;
	localparam int IW        = bffa_pkg::IDX_W;
	localparam int PW        = bffa_pkg::WPTR_W;
	localparam int WW        = bffa_pkg::WORD_W;
	localparam int NUM_WORDS = (MAX_ENTRIES + WW - 1) / WW;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_ARD   = 4'd2;
	localparam logic [3:0] ST_ASCAN = 4'd3;
	localparam logic [3:0] ST_HSAME = 4'd4;
	localparam logic [3:0] ST_HRD   = 4'd5;
	localparam logic [3:0] ST_HSCAN = 4'd6;
	localparam logic [3:0] ST_FRD   = 4'd7;
	localparam logic [3:0] ST_FCHK  = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;

	logic [3:0]             state_q;
	logic [AW-1:0]          clr_q;
	logic [PW-1:0]          wptr_q;
	logic [CW-1:0]          used_q;
	logic [CW-1:0]          hint_q;
	logic [IW-1:0]          idx_q;
	logic [WW-1:0]          word_q;
	logic [CW-1:0]          lo_q;
	logic [IW-1:0]          granted_q;
	logic [bffa_pkg::STAT_W-1:0] status_q;

	logic                   rsp_valid_q;
	logic [bffa_pkg::STAT_W-1:0] rsp_status_q;
	logic [IW-1:0]          rsp_granted_q;
	logic [CW-1:0]          rsp_free_q;
	logic [CW-1:0]          rsp_hint_q;

	logic [CW-1:0]          cfg_count;
	logic [CW-1:0]          cnt;
	logic [CW-1:0]          free_cnt;
	logic [CW-1:0]          base;
	logic                   last_word;
	logic                   acc;
	logic                   idx_range;
	logic                   fin_load;
	logic                   bit_used;

	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [WW-1:0]          mem_wdata;
	logic                   mem_re;
	logic [WW-1:0]          mem_rdata;

	bffa_pkg::scan_req_t    scan_req;
	bffa_pkg::scan_rsp_t    scan_rsp;

	bffa_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.entry_count (cfg_count)
	);

	bffa_map_ram #(
		.DEPTH (NUM_WORDS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.re      (mem_re),
		.rd_addr (AW'(wptr_q)),
		.rd_data (mem_rdata)
	);

	bffa_scan u_scan (
		.req (scan_req),
		.rsp (scan_rsp)
	);

	assign cnt = (32'(cfg_count) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : cfg_count;
	assign free_cnt = (cnt > used_q) ? (cnt - used_q) : '0;
	assign base = {wptr_q, {bffa_pkg::OFF_W{1'b0}}};
	assign last_word = ({1'b0, base} + 12'(WW)) >= {1'b0, cnt};
	assign acc = req.valid && req.ready;
	assign idx_range = {1'b0, req.entry_index} >= cnt;
	assign fin_load = (state_q == ST_FIN) && (!rsp_valid_q || rsp.ready);
	assign bit_used = mem_rdata[idx_q[bffa_pkg::OFF_W-1:0]];

	assign req.ready = (state_q == ST_IDLE);

	always_comb begin
		scan_req.word = (state_q == ST_HSAME) ? word_q : mem_rdata;
		scan_req.base = base;
		scan_req.lo   = (state_q == ST_HSAME) ? lo_q : base;
		scan_req.hi   = cnt;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(wptr_q);
		mem_wdata = mem_rdata;
		mem_re    = (state_q == ST_ARD) || (state_q == ST_HRD) || (state_q == ST_FRD);
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == ST_ASCAN && scan_rsp.found) begin
			mem_we    = 1'b1;
			mem_wdata = mem_rdata | (32'd1 << scan_rsp.index[bffa_pkg::OFF_W-1:0]);
		end else if (state_q == ST_FCHK && bit_used) begin
			mem_we    = 1'b1;
			mem_wdata = mem_rdata & ~(32'd1 << idx_q[bffa_pkg::OFF_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			wptr_q  <= '0;
			used_q  <= '0;
			hint_q  <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NUM_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						if (!req.mode) begin
							wptr_q  <= '0;
							state_q <= (cnt == '0) ? ST_FIN : ST_ARD;
						end else begin
							wptr_q  <= {1'b0, req.entry_index[IW-1:bffa_pkg::OFF_W]};
							state_q <= idx_range ? ST_FIN : ST_FRD;
						end
					end
				end
				ST_ARD: begin
					state_q <= ST_ASCAN;
				end
				ST_ASCAN: begin
					if (scan_rsp.found) begin
						used_q  <= used_q + 1'b1;
						state_q <= ST_HSAME;
					end else if (last_word) begin
						state_q <= ST_FIN;
					end else begin
						wptr_q  <= wptr_q + 1'b1;
						state_q <= ST_ARD;
					end
				end
				ST_HSAME, ST_HSCAN: begin
					if (scan_rsp.found) begin
						hint_q  <= scan_rsp.index;
						state_q <= ST_FIN;
					end else if (last_word) begin
						hint_q  <= cnt;
						state_q <= ST_FIN;
					end else begin
						wptr_q  <= wptr_q + 1'b1;
						state_q <= ST_HRD;
					end
				end
				ST_HRD: begin
					state_q <= ST_HSCAN;
				end
				ST_FRD: begin
					state_q <= ST_FCHK;
				end
				ST_FCHK: begin
					if (bit_used) begin
						if (used_q != '0) begin
							used_q <= used_q - 1'b1;
						end
						if ({1'b0, idx_q} < hint_q) begin
							hint_q <= {1'b0, idx_q};
						end
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			idx_q     <= req.entry_index;
			granted_q <= '0;
			if (!req.mode) begin
				status_q <= (cnt == '0) ? bffa_pkg::STAT_NO_FREE : bffa_pkg::STAT_OK;
			end else begin
				status_q <= idx_range ? bffa_pkg::STAT_RANGE : bffa_pkg::STAT_OK;
			end
		end
		if (state_q == ST_ASCAN) begin
			if (scan_rsp.found) begin
				granted_q <= scan_rsp.index[IW-1:0];
				word_q    <= mem_wdata;
				lo_q      <= scan_rsp.index + 1'b1;
			end else if (last_word) begin
				status_q <= bffa_pkg::STAT_NO_FREE;
			end
		end
		if (state_q == ST_FCHK && !bit_used) begin
			status_q <= bffa_pkg::STAT_ALREADY_FREE;
		end
		if (fin_load) begin
			rsp_status_q  <= status_q;
			rsp_granted_q <= granted_q;
			rsp_free_q    <= free_cnt;
			rsp_hint_q    <= hint_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.granted_index   = rsp_granted_q;
	assign rsp.free_count      = rsp_free_q;
	assign rsp.first_free_hint = rsp_hint_q;

	a_no_free_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == bffa_pkg::STAT_NO_FREE |-> rsp.free_count == '0)
		else $error("no-free result reports free entries");

	a_grant_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != bffa_pkg::STAT_OK |-> rsp.granted_index == '0)
		else $error("nonzero granted index on a failed request");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("item accepted while the previous one is in work");

endmodule
`default_nettype wire
